// ===== sv/swst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swst_pkg
// Shared types, widths, codes and the arithmetic micro-program of the
// sphere wrap state tracker.
// ---------------------------------------------------------------------------
package swst_pkg;

  localparam int COORD_BITS = 20;
  localparam int COUNT_BITS = 16;
  localparam int PROJ_BITS  = 24;
  localparam int RAD_W      = 19;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int SPLIT      = 22;
  localparam int VEC_W      = 2 * SPLIT;
  localparam int OPND_W     = SPLIT + 1;
  localparam int PROD_W     = 2 * OPND_W;
  localparam int ACC_W      = 2 * VEC_W;

  localparam int IN_FIELD_W = 1 + 9 * COORD_BITS + PROJ_BITS;
  localparam int IN_DATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = (((2 + COUNT_BITS) + 7) / 8) * 8;

  localparam int OFS_OP   = 0;
  localparam int OFS_PT   = 1;
  localparam int OFS_PROJ = 1 + 9 * COORD_BITS;

  localparam logic [RAD_W-1:0] RAD_RESET = RAD_W'(256);

  localparam logic signed [COUNT_BITS-1:0] COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_POS = 2'd1;
  localparam logic [1:0] MODE_NEG = 2'd2;

  localparam logic OP_GEOM = 1'b0;
  localparam logic OP_PROJ = 1'b1;

  // operand sources
  localparam logic [4:0] SEL_A0  = 5'd0;
  localparam logic [4:0] SEL_A1  = 5'd1;
  localparam logic [4:0] SEL_A2  = 5'd2;
  localparam logic [4:0] SEL_B0  = 5'd3;
  localparam logic [4:0] SEL_B1  = 5'd4;
  localparam logic [4:0] SEL_B2  = 5'd5;
  localparam logic [4:0] SEL_D0  = 5'd6;
  localparam logic [4:0] SEL_D1  = 5'd7;
  localparam logic [4:0] SEL_D2  = 5'd8;
  localparam logic [4:0] SEL_N0  = 5'd9;
  localparam logic [4:0] SEL_N1  = 5'd10;
  localparam logic [4:0] SEL_N2  = 5'd11;
  localparam logic [4:0] SEL_AD0 = 5'd12;
  localparam logic [4:0] SEL_AD1 = 5'd13;
  localparam logic [4:0] SEL_AD2 = 5'd14;
  localparam logic [4:0] SEL_NP0 = 5'd15;
  localparam logic [4:0] SEL_NP1 = 5'd16;
  localparam logic [4:0] SEL_NP2 = 5'd17;
  localparam logic [4:0] SEL_DD  = 5'd18;
  localparam logic [4:0] SEL_RR  = 5'd19;
  localparam logic [4:0] SEL_RAD = 5'd20;

  // operand slices: short value, low unsigned half, high signed half
  localparam logic [1:0] SL_S = 2'd0;
  localparam logic [1:0] SL_L = 2'd1;
  localparam logic [1:0] SL_H = 2'd2;

  localparam logic [1:0] ACC_SET = 2'd0;
  localparam logic [1:0] ACC_ADD = 2'd1;
  localparam logic [1:0] ACC_SUB = 2'd2;

  localparam logic [3:0] WB_NONE  = 4'd0;
  localparam logic [3:0] WB_N0    = 4'd1;
  localparam logic [3:0] WB_N1    = 4'd2;
  localparam logic [3:0] WB_N2    = 4'd3;
  localparam logic [3:0] WB_AD0   = 4'd4;
  localparam logic [3:0] WB_AD1   = 4'd5;
  localparam logic [3:0] WB_AD2   = 4'd6;
  localparam logic [3:0] WB_DD    = 4'd7;
  localparam logic [3:0] WB_RR    = 4'd8;
  localparam logic [3:0] WB_AB    = 4'd9;
  localparam logic [3:0] WB_BELOW = 4'd10;
  localparam logic [3:0] WB_FLIP  = 4'd11;

  localparam int NUM_UOPS = 47;
  localparam int STEP_W   = $clog2(NUM_UOPS);

  typedef struct packed {
    logic [4:0] xsel;
    logic [1:0] xsl;
    logic [4:0] ysel;
    logic [1:0] ysl;
    logic [1:0] accop;
    logic [3:0] wb;
  } uop_t;

  typedef struct packed {
    logic load;
    logic uop_valid;
    uop_t uop;
    logic geo_commit;
    logic proj_commit;
  } dp_cmd_t;

  function automatic uop_t mk(logic [4:0] xs, logic [1:0] xl, logic [4:0] ys,
                              logic [1:0] yl, logic [1:0] op, logic [3:0] wb);
    uop_t u;
    u.xsel  = xs;
    u.xsl   = xl;
    u.ysel  = ys;
    u.ysl   = yl;
    u.accop = op;
    u.wb    = wb;
    return u;
  endfunction

  // cross products, |d|^2, r^2, a.b, |a x d|^2 - r^2|d|^2, n.n_prev
  function automatic uop_t ucode(logic [STEP_W-1:0] step);
    uop_t u;
    u = mk(SEL_A0, SL_S, SEL_A0, SL_S, ACC_ADD, WB_NONE);
    case (step)
      6'd0:  u = mk(SEL_A1, SL_S, SEL_B2, SL_S, ACC_SET, WB_NONE);
      6'd1:  u = mk(SEL_A2, SL_S, SEL_B1, SL_S, ACC_SUB, WB_N0);
      6'd2:  u = mk(SEL_A2, SL_S, SEL_B0, SL_S, ACC_SET, WB_NONE);
      6'd3:  u = mk(SEL_A0, SL_S, SEL_B2, SL_S, ACC_SUB, WB_N1);
      6'd4:  u = mk(SEL_A0, SL_S, SEL_B1, SL_S, ACC_SET, WB_NONE);
      6'd5:  u = mk(SEL_A1, SL_S, SEL_B0, SL_S, ACC_SUB, WB_N2);
      6'd6:  u = mk(SEL_A1, SL_S, SEL_D2, SL_S, ACC_SET, WB_NONE);
      6'd7:  u = mk(SEL_A2, SL_S, SEL_D1, SL_S, ACC_SUB, WB_AD0);
      6'd8:  u = mk(SEL_A2, SL_S, SEL_D0, SL_S, ACC_SET, WB_NONE);
      6'd9:  u = mk(SEL_A0, SL_S, SEL_D2, SL_S, ACC_SUB, WB_AD1);
      6'd10: u = mk(SEL_A0, SL_S, SEL_D1, SL_S, ACC_SET, WB_NONE);
      6'd11: u = mk(SEL_A1, SL_S, SEL_D0, SL_S, ACC_SUB, WB_AD2);
      6'd12: u = mk(SEL_D0, SL_S, SEL_D0, SL_S, ACC_SET, WB_NONE);
      6'd13: u = mk(SEL_D1, SL_S, SEL_D1, SL_S, ACC_ADD, WB_NONE);
      6'd14: u = mk(SEL_D2, SL_S, SEL_D2, SL_S, ACC_ADD, WB_DD);
      6'd15: u = mk(SEL_RAD, SL_S, SEL_RAD, SL_S, ACC_SET, WB_RR);
      6'd16: u = mk(SEL_A0, SL_S, SEL_B0, SL_S, ACC_SET, WB_NONE);
      6'd17: u = mk(SEL_A1, SL_S, SEL_B1, SL_S, ACC_ADD, WB_NONE);
      6'd18: u = mk(SEL_A2, SL_S, SEL_B2, SL_S, ACC_ADD, WB_AB);
      6'd19: u = mk(SEL_AD0, SL_L, SEL_AD0, SL_L, ACC_SET, WB_NONE);
      6'd20: u = mk(SEL_AD0, SL_L, SEL_AD0, SL_H, ACC_ADD, WB_NONE);
      6'd21: u = mk(SEL_AD0, SL_H, SEL_AD0, SL_L, ACC_ADD, WB_NONE);
      6'd22: u = mk(SEL_AD0, SL_H, SEL_AD0, SL_H, ACC_ADD, WB_NONE);
      6'd23: u = mk(SEL_AD1, SL_L, SEL_AD1, SL_L, ACC_ADD, WB_NONE);
      6'd24: u = mk(SEL_AD1, SL_L, SEL_AD1, SL_H, ACC_ADD, WB_NONE);
      6'd25: u = mk(SEL_AD1, SL_H, SEL_AD1, SL_L, ACC_ADD, WB_NONE);
      6'd26: u = mk(SEL_AD1, SL_H, SEL_AD1, SL_H, ACC_ADD, WB_NONE);
      6'd27: u = mk(SEL_AD2, SL_L, SEL_AD2, SL_L, ACC_ADD, WB_NONE);
      6'd28: u = mk(SEL_AD2, SL_L, SEL_AD2, SL_H, ACC_ADD, WB_NONE);
      6'd29: u = mk(SEL_AD2, SL_H, SEL_AD2, SL_L, ACC_ADD, WB_NONE);
      6'd30: u = mk(SEL_AD2, SL_H, SEL_AD2, SL_H, ACC_ADD, WB_NONE);
      6'd31: u = mk(SEL_RR, SL_L, SEL_DD, SL_L, ACC_SUB, WB_NONE);
      6'd32: u = mk(SEL_RR, SL_L, SEL_DD, SL_H, ACC_SUB, WB_NONE);
      6'd33: u = mk(SEL_RR, SL_H, SEL_DD, SL_L, ACC_SUB, WB_NONE);
      6'd34: u = mk(SEL_RR, SL_H, SEL_DD, SL_H, ACC_SUB, WB_BELOW);
      6'd35: u = mk(SEL_N0, SL_L, SEL_NP0, SL_L, ACC_SET, WB_NONE);
      6'd36: u = mk(SEL_N0, SL_L, SEL_NP0, SL_H, ACC_ADD, WB_NONE);
      6'd37: u = mk(SEL_N0, SL_H, SEL_NP0, SL_L, ACC_ADD, WB_NONE);
      6'd38: u = mk(SEL_N0, SL_H, SEL_NP0, SL_H, ACC_ADD, WB_NONE);
      6'd39: u = mk(SEL_N1, SL_L, SEL_NP1, SL_L, ACC_ADD, WB_NONE);
      6'd40: u = mk(SEL_N1, SL_L, SEL_NP1, SL_H, ACC_ADD, WB_NONE);
      6'd41: u = mk(SEL_N1, SL_H, SEL_NP1, SL_L, ACC_ADD, WB_NONE);
      6'd42: u = mk(SEL_N1, SL_H, SEL_NP1, SL_H, ACC_ADD, WB_NONE);
      6'd43: u = mk(SEL_N2, SL_L, SEL_NP2, SL_L, ACC_ADD, WB_NONE);
      6'd44: u = mk(SEL_N2, SL_L, SEL_NP2, SL_H, ACC_ADD, WB_NONE);
      6'd45: u = mk(SEL_N2, SL_H, SEL_NP2, SL_L, ACC_ADD, WB_NONE);
      6'd46: u = mk(SEL_N2, SL_H, SEL_NP2, SL_H, ACC_ADD, WB_FLIP);
      default: u = mk(SEL_A0, SL_S, SEL_A0, SL_S, ACC_ADD, WB_NONE);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

// ===== sv/sphere_wrap_state_tracker_unit.sv =====
// geometry item: one shared 23x23 multiplier runs a 47-step multiply-accumulate
//   program in S_RUN, then the item passes through S_DRAIN to S_DONE and commits
// projection item: goes from S_IDLE straight to S_DONE and commits, skipping the program
// next item is taken the cycle after the commit; a waiting result holds the
//   commit back
// reset (rst_n low, synchronous): not wrapping, counter 0, radius 256
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sphere_wrap_state_tracker_unit
// Tracks wrapping of a path around a sphere and a revolution counter.
// ---------------------------------------------------------------------------
module sphere_wrap_state_tracker_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // operation, insert_x/y/z, fix_x/y/z, centre_x/y/z, proj_value
  input  wire logic [swst_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // wrap_mode, revolutions
  output logic [swst_pkg::OUT_DATA_W-1:0]          out_tdata,
  input  wire logic                                cfg_wr_en,
  input  wire logic [swst_pkg::RAD_W-1:0]          cfg_wr_data
);

  swst_pkg::dp_cmd_t cmd;
  logic [1:0] mode;
  logic signed [swst_pkg::COUNT_BITS-1:0] revolutions;

  swst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tdata[swst_pkg::OFS_OP]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  swst_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mode        (mode),
    .revolutions (revolutions)
  );

  assign out_tdata = {{(swst_pkg::OUT_DATA_W - 2 - swst_pkg::COUNT_BITS){1'b0}},
                      revolutions, mode};

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in flight");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without an item in flight");

  a_geo_only_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.geo_commit |-> !cmd.uop_valid && !$past(cmd.uop_valid))
    else $error("geometry commit before the program drained");
`endif

endmodule
`default_nettype wire

// ===== sv/swst_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swst_datapath
// Difference vectors, shared multiply-accumulate unit and the wrap state
// registers (mode, previous normal, projection sign, revolution counter).
// ---------------------------------------------------------------------------
module swst_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire swst_pkg::dp_cmd_t                   cmd,
  input  wire logic [swst_pkg::IN_DATA_W-1:0]      in_tdata,
  input  wire logic                                cfg_wr_en,
  input  wire logic [swst_pkg::RAD_W-1:0]          cfg_wr_data,
  output logic [1:0]                               mode,
  output logic signed [swst_pkg::COUNT_BITS-1:0]   revolutions
);

  localparam int CW = swst_pkg::COORD_BITS;
  localparam int DW = swst_pkg::DIFF_W;
  localparam int VW = swst_pkg::VEC_W;
  localparam int OW = swst_pkg::OPND_W;
  localparam int PW = swst_pkg::PROD_W;
  localparam int AW = swst_pkg::ACC_W;
  localparam int SP = swst_pkg::SPLIT;

  logic [swst_pkg::RAD_W-1:0] radius_r;

  logic signed [DW-1:0] a_r [3];
  logic signed [DW-1:0] b_r [3];
  logic signed [DW-1:0] d_r [3];
  logic signed [VW-1:0] n_r [3];
  logic signed [VW-1:0] ad_r [3];
  logic signed [VW-1:0] np_r [3];
  logic signed [VW-1:0] dd_r;
  logic signed [VW-1:0] rr_r;

  logic signed [PW-1:0] prod_r;
  logic                 pv_r;
  logic [1:0]           hcnt_r;
  logic [1:0]           accop_r;
  logic [3:0]           wb_r;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] acc_nxt;

  logic ab_neg_r, below_r, flip_r;
  logic s_pos_r, s_neg_r;
  logic prev_pos_r, prev_neg_r;
  logic first_r;
  logic [1:0] mode_r, mode_nxt;
  logic signed [swst_pkg::COUNT_BITS-1:0] rev_r, rev_nxt;

  logic signed [CW-1:0] pt [9];
  logic signed [VW-1:0] xsrc, ysrc;
  logic signed [OW-1:0] xop, yop;
  logic signed [AW-1:0] pext, psh;
  logic az, bz, dz, below, above, flip;
  logic inc, dec;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      pt[i] = in_tdata[swst_pkg::OFS_PT + i*CW +: CW];
    end
  end

  function automatic logic signed [VW-1:0] pick(
      input logic [4:0] sel,
      input logic signed [DW-1:0] av [3], input logic signed [DW-1:0] bv [3],
      input logic signed [DW-1:0] dv [3], input logic signed [VW-1:0] nv [3],
      input logic signed [VW-1:0] adv [3], input logic signed [VW-1:0] npv [3],
      input logic signed [VW-1:0] ddv, input logic signed [VW-1:0] rrv,
      input logic [swst_pkg::RAD_W-1:0] rad);
    logic signed [VW-1:0] v;
    unique case (sel)
      swst_pkg::SEL_A0:  v = VW'(av[0]);
      swst_pkg::SEL_A1:  v = VW'(av[1]);
      swst_pkg::SEL_A2:  v = VW'(av[2]);
      swst_pkg::SEL_B0:  v = VW'(bv[0]);
      swst_pkg::SEL_B1:  v = VW'(bv[1]);
      swst_pkg::SEL_B2:  v = VW'(bv[2]);
      swst_pkg::SEL_D0:  v = VW'(dv[0]);
      swst_pkg::SEL_D1:  v = VW'(dv[1]);
      swst_pkg::SEL_D2:  v = VW'(dv[2]);
      swst_pkg::SEL_N0:  v = nv[0];
      swst_pkg::SEL_N1:  v = nv[1];
      swst_pkg::SEL_N2:  v = nv[2];
      swst_pkg::SEL_AD0: v = adv[0];
      swst_pkg::SEL_AD1: v = adv[1];
      swst_pkg::SEL_AD2: v = adv[2];
      swst_pkg::SEL_NP0: v = npv[0];
      swst_pkg::SEL_NP1: v = npv[1];
      swst_pkg::SEL_NP2: v = npv[2];
      swst_pkg::SEL_DD:  v = ddv;
      swst_pkg::SEL_RR:  v = rrv;
      swst_pkg::SEL_RAD: v = $signed({{(VW-swst_pkg::RAD_W){1'b0}}, rad});
      default:           v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [OW-1:0] slice(input logic [1:0] sl,
                                                 input logic signed [VW-1:0] v);
    logic signed [OW-1:0] o;
    unique case (sl)
      swst_pkg::SL_S: o = v[OW-1:0];
      swst_pkg::SL_L: o = $signed({1'b0, v[SP-1:0]});
      swst_pkg::SL_H: o = $signed({v[VW-1], v[VW-1:SP]});
      default:        o = '0;
    endcase
    return o;
  endfunction

  always_comb begin
    xsrc = pick(cmd.uop.xsel, a_r, b_r, d_r, n_r, ad_r, np_r, dd_r, rr_r, radius_r);
    ysrc = pick(cmd.uop.ysel, a_r, b_r, d_r, n_r, ad_r, np_r, dd_r, rr_r, radius_r);
    xop  = slice(cmd.uop.xsl, xsrc);
    yop  = slice(cmd.uop.ysl, ysrc);
  end

  // partial product weighted by 2^(22 * number of high halves)
  always_comb begin
    pext = AW'(prod_r);
    case (hcnt_r)
      2'd1:    psh = pext <<< SP;
      2'd2:    psh = pext <<< (2*SP);
      default: psh = pext;
    endcase
    acc_nxt = acc_r;
    if (pv_r) begin
      case (accop_r)
        swst_pkg::ACC_SET: acc_nxt = psh;
        swst_pkg::ACC_SUB: acc_nxt = acc_r - psh;
        default:           acc_nxt = acc_r + psh;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= swst_pkg::RAD_RESET;
      pv_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        radius_r <= cfg_wr_data;
      end
      pv_r <= cmd.uop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 3; k++) begin
        a_r[k] <= DW'(pt[k]) - DW'(pt[6+k]);
        b_r[k] <= DW'(pt[3+k]) - DW'(pt[6+k]);
        d_r[k] <= DW'(pt[k]) - DW'(pt[3+k]);
      end
      s_neg_r <= in_tdata[swst_pkg::OFS_PROJ + swst_pkg::PROJ_BITS - 1];
      s_pos_r <= !in_tdata[swst_pkg::OFS_PROJ + swst_pkg::PROJ_BITS - 1] &&
                 (in_tdata[swst_pkg::OFS_PROJ +: swst_pkg::PROJ_BITS] != '0);
    end
    prod_r  <= xop * yop;
    hcnt_r  <= 2'((cmd.uop.xsl == swst_pkg::SL_H)) + 2'((cmd.uop.ysl == swst_pkg::SL_H));
    accop_r <= cmd.uop.accop;
    wb_r    <= cmd.uop.wb;
    acc_r   <= acc_nxt;
    if (pv_r) begin
      case (wb_r)
        swst_pkg::WB_N0:    n_r[0]   <= acc_nxt[VW-1:0];
        swst_pkg::WB_N1:    n_r[1]   <= acc_nxt[VW-1:0];
        swst_pkg::WB_N2:    n_r[2]   <= acc_nxt[VW-1:0];
        swst_pkg::WB_AD0:   ad_r[0]  <= acc_nxt[VW-1:0];
        swst_pkg::WB_AD1:   ad_r[1]  <= acc_nxt[VW-1:0];
        swst_pkg::WB_AD2:   ad_r[2]  <= acc_nxt[VW-1:0];
        swst_pkg::WB_DD:    dd_r     <= acc_nxt[VW-1:0];
        swst_pkg::WB_RR:    rr_r     <= acc_nxt[VW-1:0];
        swst_pkg::WB_AB:    ab_neg_r <= acc_nxt[AW-1];
        swst_pkg::WB_BELOW: below_r  <= acc_nxt[AW-1];
        swst_pkg::WB_FLIP:  flip_r   <= acc_nxt[AW-1];
        default: ;
      endcase
    end
  end

  always_comb begin
    az    = (a_r[0] == '0) && (a_r[1] == '0) && (a_r[2] == '0);
    bz    = (b_r[0] == '0) && (b_r[1] == '0) && (b_r[2] == '0);
    dz    = (d_r[0] == '0) && (d_r[1] == '0) && (d_r[2] == '0);
    below = !az && !dz && below_r;
    above = !az && !dz && !below_r;
    // first geometry item has no previous normal, never a flip
    flip  = flip_r && !first_r;

    mode_nxt = mode_r;
    case (mode_r)
      swst_pkg::MODE_OFF: begin
        if (below && !bz && ab_neg_r) begin
          mode_nxt = swst_pkg::MODE_POS;
        end
      end
      swst_pkg::MODE_POS: begin
        if (above && rev_r == '0) begin
          mode_nxt = swst_pkg::MODE_OFF;
        end else if (flip) begin
          mode_nxt = swst_pkg::MODE_NEG;
        end
      end
      swst_pkg::MODE_NEG: begin
        if (flip) begin
          mode_nxt = swst_pkg::MODE_POS;
        end
      end
      default: mode_nxt = mode_r;
    endcase

    inc = 1'b0;
    dec = 1'b0;
    if (mode_r == swst_pkg::MODE_POS) begin
      inc = prev_pos_r && s_neg_r;
      dec = prev_neg_r && s_pos_r;
    end else if (mode_r == swst_pkg::MODE_NEG) begin
      inc = prev_neg_r && s_pos_r;
      dec = prev_pos_r && s_neg_r;
    end
    rev_nxt = rev_r;
    if (inc && rev_r != swst_pkg::COUNT_MAX) begin
      rev_nxt = rev_r + 1'b1;
    end else if (dec && rev_r != swst_pkg::COUNT_MIN) begin
      rev_nxt = rev_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= swst_pkg::MODE_OFF;
      rev_r      <= '0;
      prev_pos_r <= 1'b0;
      prev_neg_r <= 1'b0;
      first_r    <= 1'b1;
      for (int k = 0; k < 3; k++) begin
        np_r[k] <= '0;
      end
    end else if (cmd.geo_commit) begin
      mode_r  <= mode_nxt;
      first_r <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        np_r[k] <= n_r[k];
      end
      if (first_r) begin
        prev_pos_r <= 1'b0;
        prev_neg_r <= 1'b0;
      end
    end else if (cmd.proj_commit) begin
      rev_r      <= rev_nxt;
      prev_pos_r <= s_pos_r;
      prev_neg_r <= s_neg_r;
    end
  end

  assign mode        = mode_r;
  assign revolutions = rev_r;

endmodule
`default_nettype wire

// ===== sv/swst_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// swst_ctrl
// Sequencer: accepts an item, steps the multiply-accumulate program for
// geometry items and commits the state when the output slot is free.
// ---------------------------------------------------------------------------
module swst_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic              in_op,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output swst_pkg::dp_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [swst_pkg::STEP_W-1:0] step_r, step_nxt;
  logic is_proj_r;
  logic out_valid_r;
  logic accept, slot_free, commit;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign commit    = (state_r == S_DONE) && slot_free;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        step_nxt = '0;
        if (accept) begin
          state_nxt = (in_op == swst_pkg::OP_PROJ) ? S_DONE : S_RUN;
        end
      end
      S_RUN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == swst_pkg::STEP_W'(swst_pkg::NUM_UOPS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_DONE;
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      is_proj_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (accept) begin
        is_proj_r <= (in_op == swst_pkg::OP_PROJ);
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    cmd.load        = accept;
    cmd.uop_valid   = (state_r == S_RUN);
    cmd.uop         = swst_pkg::ucode(step_r);
    cmd.geo_commit  = commit && !is_proj_r;
    cmd.proj_commit = commit && is_proj_r;
  end

  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// ===== test/tb_sphere_wrap_state_tracker_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sphere_wrap_state_tracker_unit
// Drives geometry and projection items through the stream ports, predicts
// wrap mode and revolution count with exact wide integer arithmetic and
// checks every result in order, over several sphere radius settings.
// ---------------------------------------------------------------------------
module tb_sphere_wrap_state_tracker_unit;

  localparam int WATCH_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RAND_PER_PHASE = 240;
  localparam int CB = swst_pkg::COORD_BITS;
  localparam int PB = swst_pkg::PROJ_BITS;
  localparam int NB = swst_pkg::COUNT_BITS;
  localparam int RW = swst_pkg::RAD_W;

  typedef logic signed [159:0] wide_t;

  typedef struct {
    logic op;
    logic signed [CB-1:0] ix, iy, iz, fx, fy, fz, cx, cy, cz;
    logic signed [PB-1:0] pv;
  } item_t;

  typedef struct {
    logic [1:0] mode;
    logic signed [NB-1:0] revs;
  } result_t;

  typedef struct {
    item_t it;
    bit typed;
    result_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [swst_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [swst_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [RW-1:0] cfg_wr_data = '0;

  sphere_wrap_state_tracker_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // tracker copy
  logic [RW-1:0] trk_radius;
  logic [1:0] trk_mode;
  wide_t trk_normal [3];
  int trk_sign;
  int trk_revs;
  bit trk_first;

  result_t pending_q[$];
  row_t rows[$];
  int err_cnt = 0;
  int n_geom = 0, n_proj = 0, n_neg_results = 0;
  bit calm = 1'b0;
  int idle_cnt = 0;

  function automatic wide_t dot3(wide_t p[3], wide_t q[3]);
    return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
  endfunction

  function automatic void cross3(wide_t p[3], wide_t q[3], output wide_t o[3]);
    o[0] = p[1] * q[2] - p[2] * q[1];
    o[1] = p[2] * q[0] - p[0] * q[2];
    o[2] = p[0] * q[1] - p[1] * q[0];
  endfunction

  function automatic bit is_zero3(wide_t v[3]);
    return v[0] == 0 && v[1] == 0 && v[2] == 0;
  endfunction

  function automatic void track_geometry(item_t it);
    wide_t a[3], b[3], d[3], n[3], ad[3];
    wide_t lhs, rhs, rr;
    bit az, bz, dz, below, above, flip;
    a[0] = wide_t'(it.ix) - wide_t'(it.cx);
    a[1] = wide_t'(it.iy) - wide_t'(it.cy);
    a[2] = wide_t'(it.iz) - wide_t'(it.cz);
    b[0] = wide_t'(it.fx) - wide_t'(it.cx);
    b[1] = wide_t'(it.fy) - wide_t'(it.cy);
    b[2] = wide_t'(it.fz) - wide_t'(it.cz);
    d[0] = wide_t'(it.ix) - wide_t'(it.fx);
    d[1] = wide_t'(it.iy) - wide_t'(it.fy);
    d[2] = wide_t'(it.iz) - wide_t'(it.fz);
    az = is_zero3(a);
    bz = is_zero3(b);
    dz = is_zero3(d);
    if (az || bz) begin
      n[0] = 0; n[1] = 0; n[2] = 0;
    end else begin
      cross3(a, b, n);
    end
    cross3(a, d, ad);
    lhs = dot3(ad, ad);
    rr = wide_t'({1'b0, trk_radius});
    rhs = rr * rr * dot3(d, d);
    below = !az && !dz && (lhs < rhs);
    above = !az && !dz && !(lhs < rhs);
    if (trk_first) begin
      trk_normal = n;
      trk_sign = 0;
    end
    flip = dot3(n, trk_normal) < 0;
    if (trk_mode == swst_pkg::MODE_OFF) begin
      if (below && !bz && dot3(a, b) < 0) trk_mode = swst_pkg::MODE_POS;
    end else if (trk_mode == swst_pkg::MODE_POS) begin
      if (above && trk_revs == 0) trk_mode = swst_pkg::MODE_OFF;
      else if (flip) trk_mode = swst_pkg::MODE_NEG;
    end else begin
      if (flip) trk_mode = swst_pkg::MODE_POS;
    end
    trk_normal = n;
    trk_first = 1'b0;
  endfunction

  function automatic void track_projection(logic signed [PB-1:0] pv);
    int s, delta;
    s = (pv > 0) ? 1 : ((pv < 0) ? -1 : 0);
    delta = 0;
    if (trk_sign < 0 && s > 0) delta = -1;
    else if (trk_sign > 0 && s < 0) delta = 1;
    if (trk_mode == swst_pkg::MODE_NEG) delta = -delta;
    else if (trk_mode != swst_pkg::MODE_POS) delta = 0;
    if (delta > 0 && trk_revs < int'(swst_pkg::COUNT_MAX)) trk_revs++;
    else if (delta < 0 && trk_revs > int'(swst_pkg::COUNT_MIN)) trk_revs--;
    trk_sign = s;
  endfunction

  function automatic result_t track_item(item_t it);
    result_t r;
    if (it.op == swst_pkg::OP_GEOM) track_geometry(it);
    else track_projection(it.pv);
    r.mode = trk_mode;
    r.revs = NB'(trk_revs);
    return r;
  endfunction

  function automatic logic [swst_pkg::IN_DATA_W-1:0] pack_item(item_t it);
    return swst_pkg::IN_DATA_W'({it.pv, it.cz, it.cy, it.cx, it.fz, it.fy, it.fx,
                                 it.iz, it.iy, it.ix, it.op});
  endfunction

  function automatic int srand(int s);
    return int'($urandom_range(0, 2 * s)) - s;
  endfunction

  function automatic item_t geo_item(int ix, int iy, int iz, int fx, int fy, int fz,
                                     int cx, int cy, int cz);
    item_t it;
    it.op = swst_pkg::OP_GEOM;
    it.ix = CB'(ix); it.iy = CB'(iy); it.iz = CB'(iz);
    it.fx = CB'(fx); it.fy = CB'(fy); it.fz = CB'(fz);
    it.cx = CB'(cx); it.cy = CB'(cy); it.cz = CB'(cz);
    it.pv = PB'($urandom);
    return it;
  endfunction

  function automatic item_t proj_item(int pv);
    item_t it;
    it = geo_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
    it.op = swst_pkg::OP_PROJ;
    it.pv = PB'(pv);
    return it;
  endfunction

  function automatic void add_row(item_t it, bit typed = 1'b0,
                                  logic [1:0] m = swst_pkg::MODE_OFF, int rv = 0);
    row_t r;
    r.it = it;
    r.typed = typed;
    r.res.mode = m;
    r.res.revs = NB'(rv);
    rows.push_back(r);
  endfunction

  // paths near a sphere with a random centre, some full-range noise, and projection items
  function automatic item_t rand_item(int span);
    int cx, cy, cz, k;
    k = $urandom_range(0, 99);
    if (k < 10)
      return geo_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom);
    if (k < 55) begin
      cx = srand(4000); cy = srand(4000); cz = srand(4000);
      return geo_item(cx + srand(span), cy + srand(span), cz + srand(span / 4),
                      cx + srand(span), cy + srand(span), cz + srand(span / 4),
                      cx, cy, cz);
    end
    k = $urandom_range(0, 99);
    if (k < 10) return proj_item(0);
    if (k < 25) return proj_item($urandom);
    return proj_item(srand(3000));
  endfunction

  task automatic send_item(item_t it, bit typed, result_t typed_res);
    result_t r;
    if (!calm && $urandom_range(0, 99) < 21) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 21);
    end
    in_tvalid <= 1'b1;
    in_tdata <= pack_item(it);
    do @(posedge clk); while (!in_tready);
    r = track_item(it);
    pending_q.push_back(typed ? typed_res : r);
    if (it.op == swst_pkg::OP_GEOM) n_geom++;
    else n_proj++;
  endtask

  task automatic write_radius(logic [RW-1:0] v);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    trk_radius = v;
  endtask

  // output side: ready pattern, checking and watchdog
  always @(posedge clk) begin
    result_t e;
    out_tready <= calm || ($urandom_range(0, 99) >= 21);
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt > WATCH_LIMIT) begin
        $display("tb_sphere_wrap_state_tracker_unit: errors");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        if (pending_q.size() == 0) begin
          $error("result with nothing expected: %h", out_tdata);
          err_cnt++;
        end else begin
          e = pending_q.pop_front();
          if (out_tdata[1:0] != e.mode) begin
            $error("wrap_mode expected %0d got %0d", e.mode, out_tdata[1:0]);
            err_cnt++;
          end
          if (out_tdata[2 +: NB] != e.revs) begin
            $error("revolutions expected %0d got %0d", e.revs,
                   $signed(out_tdata[2 +: NB]));
            err_cnt++;
          end
          if (e.mode == swst_pkg::MODE_NEG) n_neg_results++;
        end
      end
    end
  end

  initial begin
    logic [RW-1:0] radii [6];
    result_t none;
    int span;
    none.mode = swst_pkg::MODE_OFF;
    none.revs = 0;
    trk_radius = swst_pkg::RAD_RESET;
    trk_mode = swst_pkg::MODE_OFF;
    trk_normal[0] = 0; trk_normal[1] = 0; trk_normal[2] = 0;
    trk_sign = 0;
    trk_revs = 0;
    trk_first = 1'b1;

    add_row(proj_item(100), 1'b1, swst_pkg::MODE_OFF, 0);
    add_row(geo_item(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, swst_pkg::MODE_OFF, 0);
    add_row(geo_item(-1000, 100, 0, 1000, 100, 0, 0, 0, 0), 1'b1,
            swst_pkg::MODE_POS, 0);
    add_row(proj_item(5));
    add_row(proj_item(-5));
    add_row(proj_item(0));
    add_row(proj_item(7));
    add_row(proj_item(-8388608));
    add_row(proj_item(8388607));
    add_row(proj_item(-1));
    // plane normal reverses: polarity flips
    add_row(geo_item(1000, 100, 0, -1000, 100, 0, 0, 0, 0));
    add_row(proj_item(1));
    add_row(proj_item(-1));
    add_row(geo_item(-1000, 100, 0, 1000, 100, 0, 0, 0, 0));
    add_row(proj_item(1));
    add_row(geo_item(524287, 524287, 524287, -524288, -524288, -524288, 0, 0, 0));
    add_row(geo_item(-524288, 524287, -524288, 524287, -524288, 524287,
                     524287, -524288, 524287));
    // insertion on fixation, insertion on centre, fixation on centre
    add_row(geo_item(300, 20, 5, 300, 20, 5, 0, 0, 0));
    add_row(geo_item(40, 40, 40, -500, 60, 0, 40, 40, 40));
    add_row(geo_item(-500, 60, 0, 40, 40, 40, 40, 40, 40));
    add_row(geo_item(-900, 50, 0, 900, 50, 0, 0, 0, 0));
    add_row(geo_item(900, 5000, 0, -900, 5000, 0, 0, 0, 0));

    radii[0] = 0;
    radii[1] = {RW{1'b1}};
    radii[2] = 256;
    radii[3] = 1000;
    radii[4] = RW'($urandom_range(1, 4000));
    radii[5] = 40;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].res);
    foreach (radii[p]) begin
      write_radius(radii[p]);
      span = (radii[p] > 8000) ? 60000 : 4 * radii[p] + 64;
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        calm = (p == 3);
        send_item(rand_item(span), 1'b0, none);
      end
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d geometry and %0d projection items over %0d radius settings",
             n_geom, n_proj, 7);
    $display("%0d results came back in negative wrap", n_neg_results);
    if (err_cnt == 0) begin
      $display("tb_sphere_wrap_state_tracker_unit: clean");
    end else begin
      $display("tb_sphere_wrap_state_tracker_unit: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/swst_pkg.sv
sv/swst_datapath.sv
sv/swst_ctrl.sv
sv/sphere_wrap_state_tracker_unit.sv
test/tb_sphere_wrap_state_tracker_unit.sv
